// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the SENT frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int CAPTURE_W = 16;
    localparam int NIB_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED  = 2'd2;

    localparam logic [15:0] SYNC_LOW_RESET  = 16'd158;
    localparam logic [15:0] SYNC_HIGH_RESET = 16'd178;
    localparam logic [3:0]  CRC_SEED_RESET  = 4'd3;

    // nibble window on (period - 1): quotient 11..26 means raw value 33..80
    localparam logic [15:0] NIB_RAW_MIN = 16'd33;
    localparam logic [15:0] NIB_RAW_MAX = 16'd80;
    // reciprocal of three for a 6-bit dividend, scaled by 2^7
    localparam logic [5:0]  DIV3_MUL    = 6'd43;

    localparam logic [3:0]  PULSE_MAX    = 4'd15;
    localparam logic [3:0]  LAST_LATCHED = 4'd4;
    localparam logic [15:0] POSITION_MAX = 16'd40950;

    localparam logic [NIB_W-1:0] CRC_TAB [16] = '{
        4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
        4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5
    };

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_DATA  = 2'd1,
        K_CRC   = 2'd2,
        K_SKIP  = 2'd3
    } pulse_kind_t;

    typedef struct packed {
        pulse_kind_t      kind;
        logic             nib_ok;
        logic [NIB_W-1:0] nib;
        logic             latch;
    } pulse_t;

endpackage

// ===== src/sfd_if.sv =====
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the SENT frame decoder.
// ----------------------------------------------------------------------------
interface sfd_capture_if;
    logic        valid;
    logic        ready;
    logic [15:0] capture_value;

    modport source (output valid, output capture_value, input ready);
    modport sink (input valid, input capture_value, output ready);
endinterface

interface sfd_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] position;
    logic [15:0] frame_count;

    modport source (output valid, output position, output frame_count, input ready);
    modport sink (input valid, input position, input frame_count, output ready);
endinterface

interface sfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// Forms the pulse period, detects sync, tracks the pulse index and turns the
// period into a nibble; pushes one classified pulse per accepted capture.
// ----------------------------------------------------------------------------
module sfd_front
    import sfd_pkg::*;
#(
    parameter int DATA_NIBBLES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] capture_value,
    input  logic [15:0] sync_low,
    input  logic [15:0] sync_high,
    output logic        push,
    output pulse_t      push_data,
    input  logic        full
);

    localparam logic [3:0] LAST_DATA = 4'(1 + DATA_NIBBLES);
    localparam logic [3:0] CRC_IDX   = 4'(2 + DATA_NIBBLES);

    logic [15:0] prev_reg, prev_next;
    logic [3:0]  pulse_idx_reg, pulse_idx_next;
    logic [15:0] diff;
    logic [16:0] period;
    logic [15:0] raw;
    logic [5:0]  raw_off;
    logic [10:0] prod;
    logic        is_sync;
    logic [3:0]  idx;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    assign diff    = capture_value - prev_reg;
    assign period  = {(diff == 16'd0), diff};
    assign raw     = diff - 16'd1;
    assign is_sync = (period > {1'b0, sync_low}) && (period < {1'b0, sync_high});
    assign idx     = is_sync ? 4'd0 : pulse_idx_reg;

    assign raw_off = raw[5:0] - NIB_RAW_MIN[5:0];
    assign prod    = 11'(raw_off) * 11'(DIV3_MUL);

    always_comb
    begin
        push_data.nib_ok = (raw >= NIB_RAW_MIN) && (raw <= NIB_RAW_MAX);
        push_data.nib    = push_data.nib_ok ? prod[10:7] : 4'd0;
        push_data.latch  = (idx <= LAST_LATCHED);
        if (idx == 4'd0)
            push_data.kind = K_START;
        else if (idx >= 4'd2 && idx <= LAST_DATA)
            push_data.kind = K_DATA;
        else if (idx == CRC_IDX)
            push_data.kind = K_CRC;
        else
            push_data.kind = K_SKIP;
    end

    always_comb
    begin
        prev_next      = prev_reg;
        pulse_idx_next = pulse_idx_reg;
        if (push)
        begin
            prev_next      = capture_value;
            pulse_idx_next = (idx < PULSE_MAX) ? idx + 4'd1 : PULSE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            pulse_idx_reg <= '0;
        end
        else
        begin
            prev_reg      <= prev_next;
            pulse_idx_reg <= pulse_idx_next;
        end
    end

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        push && is_sync |-> push_data.kind == K_START)
        else $error("sync pulse not classified as frame start");

    a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
        push && pulse_idx_reg != PULSE_MAX && !is_sync |=> pulse_idx_reg == $past(pulse_idx_reg) + 4'd1)
        else $error("pulse index did not advance");

endmodule

// ===== src/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry queue of classified pulses between front and back.
// ----------------------------------------------------------------------------
module sfd_queue
    import sfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  pulse_t push_data,
    output logic   full,
    input  logic   pop,
    output pulse_t pop_data,
    output logic   empty
);

    pulse_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

// ===== src/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// Runs the CRC4 over data nibbles, latches the position nibbles and emits
// position and frame count on a good CRC pulse through an output register.
// ----------------------------------------------------------------------------
module sfd_back
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  crc_seed,
    input  logic        empty,
    input  pulse_t      pop_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] position,
    output logic [15:0] frame_count
);

    logic [3:0]  crc_reg, crc_next;
    logic [11:0] nibs_reg, nibs_next;
    logic        bad_reg, bad_next;
    logic [15:0] good_reg, good_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] position_reg, position_next;
    logic [15:0] count_reg, count_next;
    logic        emit;
    logic        crc_bad;

    assign pop         = !empty && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign frame_count = count_reg;

    assign crc_bad = bad_reg || !pop_data.nib_ok;
    assign emit    = pop && (pop_data.kind == K_CRC) && !crc_bad && (pop_data.nib == crc_reg);

    always_comb
    begin
        crc_next  = crc_reg;
        nibs_next = nibs_reg;
        bad_next  = bad_reg;
        if (pop)
        begin
            unique case (pop_data.kind)
                K_START:
                begin
                    crc_next = crc_seed;
                    bad_next = 1'b0;
                end
                K_DATA:
                begin
                    if (!pop_data.nib_ok)
                        bad_next = 1'b1;
                    else
                    begin
                        crc_next = CRC_TAB[crc_reg ^ pop_data.nib];
                        if (pop_data.latch)
                            nibs_next = {nibs_reg[7:0], pop_data.nib};
                    end
                end
                K_CRC:
                    bad_next = crc_bad;
                K_SKIP:
                    ;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        good_next      = good_reg;
        out_valid_next = out_valid_reg;
        position_next  = position_reg;
        count_next     = count_reg;
        if (emit)
        begin
            good_next      = good_reg + 16'd1;
            out_valid_next = 1'b1;
            position_next  = {1'b0, nibs_reg, 3'b000} + {3'b000, nibs_reg, 1'b0};
            count_next     = good_reg + 16'd1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        position_reg <= position_next;
        count_reg    <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_SEED_RESET;
            nibs_reg      <= '0;
            bad_reg       <= 1'b0;
            good_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            nibs_reg      <= nibs_next;
            bad_reg       <= bad_next;
            good_reg      <= good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> good_reg == $past(good_reg) + 16'd1 && count_reg == good_reg)
        else $error("frame count not advanced by one on a good frame");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg && position_reg <= POSITION_MAX)
        else $error("position out of range");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !pop)
        else $error("pulse consumed while result stalled");

endmodule

// ===== src/sent_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// sent_frame_decoder
// SENT (CRC4) frame decoder working from falling-edge capture timestamps.
// ----------------------------------------------------------------------------
// Each accepted capture timestamp is one falling edge. The front computes the
// period since the previous edge, detects sync pulses (period strictly between
// sync_low and sync_high) and converts the period to a nibble; a two-entry
// queue hands the classified pulse to the back, which runs the CRC4 and, on a
// good CRC pulse, presents position and frame count in an output register.
// One capture is taken per clock cycle; the input stalls only when the output
// register is held and the queue has filled. A result is registered once its
// CRC pulse leaves the queue. Configuration writes are always ready and apply
// to the next pulse (sync bounds) or next frame start (CRC seed).
// ----------------------------------------------------------------------------
module sent_frame_decoder
    import sfd_pkg::*;
#(
    parameter int DATA_NIBBLES = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    sfd_capture_if.sink  capture,
    sfd_result_if.source result,
    sfd_cfg_if.sink      cfg
);

    logic [15:0] sync_low_reg, sync_low_next;
    logic [15:0] sync_high_reg, sync_high_next;
    logic [3:0]  crc_seed_reg, crc_seed_next;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    pulse_t      push_data;
    pulse_t      pop_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        sync_low_next  = sync_low_reg;
        sync_high_next = sync_high_reg;
        crc_seed_next  = crc_seed_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SYNC_LOW:  sync_low_next  = cfg.data;
                REG_SYNC_HIGH: sync_high_next = cfg.data;
                REG_CRC_SEED:  crc_seed_next  = cfg.data[3:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_low_reg  <= SYNC_LOW_RESET;
            sync_high_reg <= SYNC_HIGH_RESET;
            crc_seed_reg  <= CRC_SEED_RESET;
        end
        else
        begin
            sync_low_reg  <= sync_low_next;
            sync_high_reg <= sync_high_next;
            crc_seed_reg  <= crc_seed_next;
        end
    end

    sfd_front #(
        .DATA_NIBBLES (DATA_NIBBLES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (capture.valid),
        .in_ready      (capture.ready),
        .capture_value (capture.capture_value),
        .sync_low      (sync_low_reg),
        .sync_high     (sync_high_reg),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .crc_seed    (crc_seed_reg),
        .empty       (empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .position    (result.position),
        .frame_count (result.frame_count)
    );

endmodule

// ===== verif/sent_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// sent_frame_decoder_tb
// Self-checking bench for the SENT frame decoder.
// ----------------------------------------------------------------------------
// A short table of capture timestamps comes first: two clean frames whose
// results are typed in, then a sync, a bad nibble, a repeated timestamp and
// counter wrap. After that, phases of generated frames run under several sync
// windows and CRC seeds, among them the crossed and widest windows. Most
// frames are well formed with random nibbles. The rest are broken: wrong CRC,
// bad nibble, cut short, run long, bad status nibble or pure noise. The
// sender idles in bursts and the receiver stalls at random or on a fixed
// pattern. In one phase the receiver holds off for a long stretch so that
// the decoder backs up into its capture input. Every accepted timestamp goes
// through a bench-side decoder model, and each result request is compared
// with the oldest predicted frame.
// ----------------------------------------------------------------------------
module sent_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int DATA_NIBBLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int DIRECTED_ROWS = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [3:0] CRC4_STEP [16] = '{
        4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
        4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5
    };

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] frame_count;
    } frame_result_t;

    typedef struct packed {
        logic [15:0] stamp;
        logic        typed;
        logic        has_frame;
        logic [15:0] position;
        logic [15:0] frame_count;
    } stim_row_t;

    // frame 1: all-zero data, seed 3 -> CRC 5; frame 2: all-15 data -> CRC 10
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'd168,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd202,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd236,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd270,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd304,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd338,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd372,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd406,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd455,   1'b1, 1'b1, 16'd0,     16'd1},
        '{16'd623,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd657,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd736,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd815,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd894,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd973,   1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd1052,  1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd1131,  1'b1, 1'b0, 16'd0,     16'd0},
        '{16'd1195,  1'b1, 1'b1, 16'd40950, 16'd2},
        '{16'd1363,  1'b0, 1'b0, 16'd0,     16'd0},
        '{16'd1397,  1'b0, 1'b0, 16'd0,     16'd0},
        '{16'd1417,  1'b0, 1'b0, 16'd0,     16'd0},
        '{16'd1417,  1'b0, 1'b0, 16'd0,     16'd0},
        '{16'd65535, 1'b0, 1'b0, 16'd0,     16'd0},
        '{16'd0,     1'b0, 1'b0, 16'd0,     16'd0}
    };

    logic clk;
    logic rst_n;

    sfd_capture_if cap_if ();
    sfd_result_if  res_if ();
    sfd_cfg_if     cfg_if ();

    sent_frame_decoder #(
        .DATA_NIBBLES(DATA_NIBBLES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .capture(cap_if),
        .result(res_if),
        .cfg(cfg_if)
    );

    // decoder model state
    logic [15:0] cfg_sync_low  = SYNC_LOW_RESET;
    logic [15:0] cfg_sync_high = SYNC_HIGH_RESET;
    logic [3:0]  cfg_seed      = CRC_SEED_RESET;
    logic [15:0] last_stamp    = '0;
    logic [3:0]  pulse_pos     = '0;
    logic [3:0]  crc_acc       = CRC_SEED_RESET;
    logic [11:0] pos_nibs      = '0;
    logic        spoiled       = 1'b0;
    logic [15:0] good_count    = '0;

    frame_result_t pending_frames [$];
    frame_result_t oldest;
    frame_result_t decoded;
    int            mismatches = 0;

    // directed row tags, applied together with the capture request
    logic        tag_typed;
    logic        tag_has;
    logic [15:0] tag_position;
    logic [15:0] tag_count;

    logic [15:0] tx_stamp;
    int          burst_left;
    bit          gaps_on;
    rx_mode_t    ready_mode;
    bit          hold_start;
    int          hold_left;
    logic [6:0]  stall_pat;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [3:0] crc4_next(input logic [3:0] acc, input logic [3:0] nib);
        return CRC4_STEP[acc ^ nib];
    endfunction

    function automatic bit decode_pulse(input logic [15:0] stamp_in, output frame_result_t res);
        logic [15:0] diff;
        int unsigned period;
        int unsigned quo;
        bit          nib_ok;
        logic [3:0]  nib;
        logic [3:0]  slot;
        bit          emit;
        emit = 1'b0;
        res = '0;
        diff = stamp_in - last_stamp;
        period = diff;
        if (period == 0)
            period = 65536;
        last_stamp = stamp_in;
        if (period > cfg_sync_low && period < cfg_sync_high)
            pulse_pos = '0;
        slot = pulse_pos;
        quo = (period - 1) / 3;
        nib_ok = (quo >= 11) && (quo <= 26);
        nib = nib_ok ? 4'(quo - 11) : 4'd0;
        if (slot == 0)
        begin
            crc_acc = cfg_seed;
            spoiled = 1'b0;
        end
        else if (slot >= 2 && slot <= 1 + DATA_NIBBLES)
        begin
            if (!nib_ok)
                spoiled = 1'b1;
            else
            begin
                crc_acc = crc4_next(crc_acc, nib);
                if (slot <= 4)
                    pos_nibs = {pos_nibs[7:0], nib};
            end
        end
        else if (slot == 2 + DATA_NIBBLES)
        begin
            if (!nib_ok)
                spoiled = 1'b1;
            if (!spoiled && nib == crc_acc)
            begin
                good_count = good_count + 16'd1;
                res.position = 16'(pos_nibs * 10);
                res.frame_count = good_count;
                emit = 1'b1;
            end
        end
        if (pulse_pos < 15)
            pulse_pos = pulse_pos + 4'd1;
        return emit;
    endfunction

    // predict on every accepted capture
    always @(posedge clk)
    begin
        if (rst_n && cap_if.valid && cap_if.ready)
        begin
            if (decode_pulse(cap_if.capture_value, decoded) && !tag_typed)
                pending_frames.push_back(decoded);
            if (tag_typed && tag_has)
                pending_frames.push_back('{tag_position, tag_count});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t unexpected result: position %0d frame_count %0d",
                         $time, res_if.position, res_if.frame_count);
                mismatches++;
            end
            else
            begin
                oldest = pending_frames.pop_front();
                if (res_if.position !== oldest.position)
                begin
                    $display("%0t position: expected %0d actual %0d",
                             $time, oldest.position, res_if.position);
                    mismatches++;
                end
                if (res_if.frame_count !== oldest.frame_count)
                begin
                    $display("%0t frame_count: expected %0d actual %0d",
                             $time, oldest.frame_count, res_if.frame_count);
                    mismatches++;
                end
            end
        end
    end

    // result receiver
    initial
    begin
        res_if.ready = 1'b0;
        hold_left = 0;
        stall_pat = 7'b1011001;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            stall_pat = {stall_pat[0], stall_pat[6:1]};
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    RX_ALWAYS: res_if.ready <= 1'b1;
                    RX_RANDOM: res_if.ready <= ($urandom_range(99, 0) < 70);
                    default:   res_if.ready <= stall_pat[0];
                endcase
            end
        end
    end

    task automatic send_capture(input logic [15:0] value);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(16, 1);
            if (gaps_on)
                gap = $urandom_range(5, 1);
        end
        if (gap > 0)
        begin
            cap_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cap_if.valid <= 1'b1;
        cap_if.capture_value <= value;
        do
            @(posedge clk);
        while (!(cap_if.valid && cap_if.ready));
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            REG_SYNC_LOW:  cfg_sync_low = value;
            REG_SYNC_HIGH: cfg_sync_high = value;
            REG_CRC_SEED:  cfg_seed = value[3:0];
            default: ;
        endcase
    endtask

    function automatic int unsigned nib_span(input logic [3:0] v);
        return 3 * v + 34 + $urandom_range(2, 0);
    endfunction

    function automatic int unsigned bad_span();
        return $urandom_range(1, 0) ? $urandom_range(33, 1) : $urandom_range(150, 82);
    endfunction

    task automatic send_frame(input bit broken);
        int unsigned spans [$];
        logic [3:0]  nib;
        logic [3:0]  acc;
        int          lo;
        int          hi;
        int          flaw;
        int          n;
        lo = cfg_sync_low;
        hi = cfg_sync_high;
        acc = cfg_seed;
        if (lo + 1 < hi)
            spans.push_back($urandom_range(hi - 1, lo + 1));
        else
            spans.push_back($urandom_range(400, 82));
        spans.push_back(nib_span(4'($urandom_range(15, 0))));
        for (int j = 0; j < DATA_NIBBLES; j++)
        begin
            nib = $urandom_range(15, 0);
            acc = crc4_next(acc, nib);
            spans.push_back(nib_span(nib));
        end
        flaw = broken ? $urandom_range(5, 0) : 6;
        if (flaw == 0)
            acc = acc ^ 4'($urandom_range(15, 1));
        spans.push_back(nib_span(acc));
        case (flaw)
            1: spans[$urandom_range(2 + DATA_NIBBLES, 2)] = bad_span();
            2:
            begin
                n = $urandom_range(7, 1);
                repeat (n) void'(spans.pop_back());
            end
            3:
            begin
                n = $urandom_range(10, 1);
                repeat (n) spans.push_back(nib_span(4'($urandom_range(15, 0))));
            end
            4: spans[1] = bad_span();
            5:
            begin
                spans.delete();
                n = $urandom_range(12, 3);
                repeat (n) spans.push_back($urandom_range(65536, 1));
            end
            default: ;
        endcase
        foreach (spans[j])
        begin
            tx_stamp = tx_stamp + 16'(spans[j]);
            send_capture(tx_stamp);
        end
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] seed_data, input int frames,
                             input int broken_pct, input bit gaps,
                             input rx_mode_t rmode, input bit hold);
        settle();
        write_reg(REG_SYNC_LOW, lo);
        write_reg(REG_SYNC_HIGH, hi);
        write_reg(REG_CRC_SEED, seed_data);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_if.valid <= 1'b0;
        gaps_on = gaps;
        ready_mode = rmode;
        burst_left = 0;
        if (hold)
            hold_start = 1'b1;
        repeat (frames) send_frame($urandom_range(99, 0) < broken_pct);
        cap_if.valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] lo;
        rst_n = 1'b0;
        cap_if.valid = 1'b0;
        cap_if.capture_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        tag_typed = 1'b0;
        tag_has = 1'b0;
        tag_position = '0;
        tag_count = '0;
        burst_left = 0;
        gaps_on = 1'b1;
        ready_mode = RX_RANDOM;
        hold_start = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            tag_typed <= DIRECTED[r].typed;
            tag_has <= DIRECTED[r].has_frame;
            tag_position <= DIRECTED[r].position;
            tag_count <= DIRECTED[r].frame_count;
            send_capture(DIRECTED[r].stamp);
        end
        tag_typed <= 1'b0;
        cap_if.valid <= 1'b0;
        tx_stamp = DIRECTED[DIRECTED_ROWS-1].stamp;

        run_phase(SYNC_LOW_RESET, SYNC_HIGH_RESET, 16'(CRC_SEED_RESET), 10, 25, 1'b1,
                  RX_RANDOM, 1'b0);
        run_phase(16'd100, 16'd130, 16'd0, 10, 25, 1'b1, RX_PATTERN, 1'b0);
        run_phase(16'd200, 16'd260, 16'hFFFF, 8, 20, 1'b0, RX_ALWAYS, 1'b0);
        // long receiver hold-off with back-to-back clean frames
        run_phase(SYNC_LOW_RESET, SYNC_HIGH_RESET, 16'd7, 8, 0, 1'b0, RX_ALWAYS, 1'b1);
        // widest window: nearly every period is a sync
        run_phase(16'd0, 16'hFFFF, 16'($urandom), 4, 25, 1'b1, RX_RANDOM, 1'b0);
        // crossed and touching bounds: no sync at all
        run_phase(16'hFFFF, 16'd0, 16'd9, 4, 25, 1'b1, RX_PATTERN, 1'b0);
        run_phase(16'd300, 16'd301, 16'd5, 4, 25, 1'b1, RX_RANDOM, 1'b0);
        repeat (3)
        begin
            lo = $urandom_range(2000, 82);
            run_phase(lo, lo + 16'($urandom_range(200, 2)), 16'($urandom), 7, 25, 1'b1,
                      rx_mode_t'($urandom_range(2, 0)), 1'b0);
        end

        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("%0t timeout with %0d results outstanding", $time, pending_frames.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sfd_pkg.sv
src/sfd_if.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/sent_frame_decoder.sv
verif/sent_frame_decoder_tb.sv
